/* hw/rtl/shape_pair_overlap_test_top_macros.svh */
// Assertion helpers for the overlap tester.
`ifndef SHAPE_PAIR_OVERLAP_TEST_TOP_MACROS_SVH
`define SHAPE_PAIR_OVERLAP_TEST_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPOT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPOT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/spot_pkg.sv */
`timescale 1ns / 1ps

package spot_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;

  localparam logic SHAPE_BOX    = 1'b0;
  localparam logic SHAPE_CIRCLE = 1'b1;

  typedef enum logic [1:0] {
    PAIR_BOX_BOX       = 2'd0,
    PAIR_CIRCLE_CIRCLE = 2'd1,
    PAIR_BOX_CIRCLE    = 2'd2
  } pair_kind_e;

  typedef struct packed {
    logic       valid;
    pair_kind_e kind;
  } stage_ctl_t;

  typedef struct packed {
    logic decided;
    logic hit;
    logic strict;
  } verdict_t;

endpackage

/* hw/rtl/spot_diff.sv */
`timescale 1ns / 1ps

module spot_diff import spot_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic                    first_is_circle_i,
  input  logic [COORD_BITS-1:0]   first_x_i,
  input  logic [COORD_BITS-1:0]   first_y_i,
  input  logic [COORD_BITS-2:0]   first_half_w_i,
  input  logic [COORD_BITS-2:0]   first_half_h_i,
  input  logic [COORD_BITS-2:0]   first_radius_i,
  input  logic                    second_is_circle_i,
  input  logic [COORD_BITS-1:0]   second_x_i,
  input  logic [COORD_BITS-1:0]   second_y_i,
  input  logic [COORD_BITS-2:0]   second_half_w_i,
  input  logic [COORD_BITS-2:0]   second_half_h_i,
  input  logic [COORD_BITS-2:0]   second_radius_i,
  output stage_ctl_t              ctl_o,
  output logic [COORD_BITS:0]     dx_o,
  output logic [COORD_BITS:0]     dy_o,
  output logic [COORD_BITS-1:0]   sw_o,
  output logic [COORD_BITS-1:0]   sh_o,
  output logic [COORD_BITS-1:0]   sr_o
);

  localparam int unsigned MSB = COORD_BITS - 1;

  stage_ctl_t              ctl_d, ctl_q;
  logic [COORD_BITS:0]     dx_s, dy_s;
  logic [COORD_BITS:0]     dx_d, dy_d, dx_q, dy_q;
  logic [COORD_BITS-1:0]   sw_d, sh_d, sr_d, sw_q, sh_q, sr_q;
  logic                    box_first;

  always_comb begin
    dx_s = {first_x_i[MSB], first_x_i} - {second_x_i[MSB], second_x_i};
    dy_s = {first_y_i[MSB], first_y_i} - {second_y_i[MSB], second_y_i};
    dx_d = dx_s[COORD_BITS] ? (~dx_s + 1'b1) : dx_s;
    dy_d = dy_s[COORD_BITS] ? (~dy_s + 1'b1) : dy_s;
    box_first = (first_is_circle_i == SHAPE_BOX);

    ctl_d.valid = valid_i;
    if ((first_is_circle_i == SHAPE_BOX) && (second_is_circle_i == SHAPE_BOX)) begin
      ctl_d.kind = PAIR_BOX_BOX;
    end else if ((first_is_circle_i == SHAPE_CIRCLE) &&
                 (second_is_circle_i == SHAPE_CIRCLE)) begin
      ctl_d.kind = PAIR_CIRCLE_CIRCLE;
    end else begin
      ctl_d.kind = PAIR_BOX_CIRCLE;
    end

    case (ctl_d.kind)
      PAIR_BOX_BOX: begin
        sw_d = {1'b0, first_half_w_i} + {1'b0, second_half_w_i};
        sh_d = {1'b0, first_half_h_i} + {1'b0, second_half_h_i};
        sr_d = '0;
      end
      PAIR_CIRCLE_CIRCLE: begin
        sw_d = '0;
        sh_d = '0;
        sr_d = {1'b0, first_radius_i} + {1'b0, second_radius_i};
      end
      default: begin
        sw_d = {1'b0, box_first ? first_half_w_i : second_half_w_i};
        sh_d = {1'b0, box_first ? first_half_h_i : second_half_h_i};
        sr_d = {1'b0, box_first ? second_radius_i : first_radius_i};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, kind: PAIR_BOX_BOX};
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    sw_q <= sw_d;
    sh_q <= sh_d;
    sr_q <= sr_d;
  end

  assign ctl_o = ctl_q;
  assign dx_o  = dx_q;
  assign dy_o  = dy_q;
  assign sw_o  = sw_q;
  assign sh_o  = sh_q;
  assign sr_o  = sr_q;

endmodule

/* hw/rtl/spot_sel.sv */
`timescale 1ns / 1ps

module spot_sel import spot_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  stage_ctl_t            ctl_i,
  input  logic [COORD_BITS:0]   dx_i,
  input  logic [COORD_BITS:0]   dy_i,
  input  logic [COORD_BITS-1:0] sw_i,
  input  logic [COORD_BITS-1:0] sh_i,
  input  logic [COORD_BITS-1:0] sr_i,
  output stage_ctl_t            ctl_o,
  output verdict_t              verdict_o,
  output logic [COORD_BITS:0]   a_o,
  output logic [COORD_BITS:0]   b_o,
  output logic [COORD_BITS:0]   c_o
);

  stage_ctl_t            ctl_q;
  verdict_t              verdict_d, verdict_q;
  logic [COORD_BITS:0]   a_d, b_d, c_d, a_q, b_q, c_q;
  logic [COORD_BITS:0]   sw_x, sh_x, sr_x, wr, hr;

  always_comb begin
    sw_x = {1'b0, sw_i};
    sh_x = {1'b0, sh_i};
    sr_x = {1'b0, sr_i};
    wr   = sw_x + sr_x;
    hr   = sh_x + sr_x;
    a_d  = dx_i;
    b_d  = dy_i;
    c_d  = sr_x;
    verdict_d = '{decided: 1'b1, hit: 1'b0, strict: 1'b0};
    case (ctl_i.kind)
      PAIR_BOX_BOX: begin
        verdict_d.hit = (dx_i < sw_x) && (dy_i < sh_x);
      end
      PAIR_CIRCLE_CIRCLE: begin
        verdict_d.decided = 1'b0;
      end
      PAIR_BOX_CIRCLE: begin
        a_d = dx_i - sw_x;
        b_d = dy_i - sh_x;
        verdict_d.strict = 1'b1;
        if (dx_i > wr) begin
          verdict_d.hit = 1'b0;
        end else if (dy_i > hr) begin
          verdict_d.hit = 1'b0;
        end else if (dx_i <= sw_x) begin
          verdict_d.hit = 1'b1;
        end else if (dy_i <= sh_x) begin
          verdict_d.hit = 1'b1;
        end else begin
          // corner region: settled by squared distance
          verdict_d.decided = 1'b0;
        end
      end
      default: begin
        verdict_d.hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, kind: PAIR_BOX_BOX};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_d;
    a_q       <= a_d;
    b_q       <= b_d;
    c_q       <= c_d;
  end

  assign ctl_o     = ctl_q;
  assign verdict_o = verdict_q;
  assign a_o       = a_q;
  assign b_o       = b_q;
  assign c_o       = c_q;

endmodule

/* hw/rtl/spot_mul.sv */
`timescale 1ns / 1ps

module spot_mul import spot_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stage_ctl_t          ctl_i,
  input  verdict_t            verdict_i,
  input  logic [COORD_BITS:0] a_i,
  input  logic [COORD_BITS:0] b_i,
  input  logic [COORD_BITS:0] c_i,
  output logic                valid_o,
  output logic                overlap_o,
  output logic [1:0]          pair_kind_o
);

  localparam int unsigned PW = 2 * COORD_BITS + 2;

  stage_ctl_t      ctl_q;
  verdict_t        verdict_q;
  logic [PW-1:0]   pa_q, pb_q, pc_q;
  logic [PW:0]     dist_sq;
  logic            sq_hit;
  logic            valid_q, overlap_d, overlap_q;
  logic [1:0]      kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '{valid: 1'b0, kind: PAIR_BOX_BOX};
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    verdict_q <= verdict_i;
    pa_q      <= a_i * a_i;
    pb_q      <= b_i * b_i;
    pc_q      <= c_i * c_i;
  end

  always_comb begin
    dist_sq   = {1'b0, pa_q} + {1'b0, pb_q};
    sq_hit    = verdict_q.strict ? (dist_sq < {1'b0, pc_q}) : (dist_sq <= {1'b0, pc_q});
    overlap_d = verdict_q.decided ? verdict_q.hit : sq_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    overlap_q <= overlap_d;
    kind_q    <= ctl_q.kind;
  end

  assign valid_o     = valid_q;
  assign overlap_o   = overlap_q;
  assign pair_kind_o = kind_q;

endmodule

/* hw/rtl/shape_pair_overlap_test_top.sv */
// Channel  | Handshake             | Signals
// ---------+-----------------------+--------------------------------------------
// request  | start_i & !busy_o     | first_*_i, second_*_i (shape, centre, sizes)
// result   | valid_o, one cycle    | overlap_o, pair_kind_o
//
// One transaction enters per cycle; its result leaves the last of the stages below.
// Stages: centre deltas, range checks and operand select, squaring, final compare.
// busy_o never rises, as nothing in the pipeline waits on the receiver.
// Reset clears only the valid bits and stage kinds; no clearing pass.
`timescale 1ns / 1ps

module shape_pair_overlap_test_top import spot_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  first_is_circle_i,
  input  logic [COORD_BITS-1:0] first_x_i,
  input  logic [COORD_BITS-1:0] first_y_i,
  input  logic [COORD_BITS-2:0] first_half_w_i,
  input  logic [COORD_BITS-2:0] first_half_h_i,
  input  logic [COORD_BITS-2:0] first_radius_i,
  input  logic                  second_is_circle_i,
  input  logic [COORD_BITS-1:0] second_x_i,
  input  logic [COORD_BITS-1:0] second_y_i,
  input  logic [COORD_BITS-2:0] second_half_w_i,
  input  logic [COORD_BITS-2:0] second_half_h_i,
  input  logic [COORD_BITS-2:0] second_radius_i,
  output logic                  valid_o,
  output logic                  overlap_o,
  output logic [1:0]            pair_kind_o
);

  stage_ctl_t            ctl1, ctl2;
  verdict_t              verdict2;
  logic [COORD_BITS:0]   dx1, dy1, a2, b2, c2;
  logic [COORD_BITS-1:0] sw1, sh1, sr1;

  assign busy_o = 1'b0;

  spot_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (start_i & ~busy_o),
    .first_is_circle_i  (first_is_circle_i),
    .first_x_i          (first_x_i),
    .first_y_i          (first_y_i),
    .first_half_w_i     (first_half_w_i),
    .first_half_h_i     (first_half_h_i),
    .first_radius_i     (first_radius_i),
    .second_is_circle_i (second_is_circle_i),
    .second_x_i         (second_x_i),
    .second_y_i         (second_y_i),
    .second_half_w_i    (second_half_w_i),
    .second_half_h_i    (second_half_h_i),
    .second_radius_i    (second_radius_i),
    .ctl_o              (ctl1),
    .dx_o               (dx1),
    .dy_o               (dy1),
    .sw_o               (sw1),
    .sh_o               (sh1),
    .sr_o               (sr1)
  );

  spot_sel #(.COORD_BITS(COORD_BITS)) u_sel (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl1),
    .dx_i      (dx1),
    .dy_i      (dy1),
    .sw_i      (sw1),
    .sh_i      (sh1),
    .sr_i      (sr1),
    .ctl_o     (ctl2),
    .verdict_o (verdict2),
    .a_o       (a2),
    .b_o       (b2),
    .c_o       (c2)
  );

  spot_mul #(.COORD_BITS(COORD_BITS)) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl2),
    .verdict_i   (verdict2),
    .a_i         (a2),
    .b_i         (b2),
    .c_i         (c2),
    .valid_o     (valid_o),
    .overlap_o   (overlap_o),
    .pair_kind_o (pair_kind_o)
  );

endmodule

/* hw/rtl/spot_checker.sv */
`timescale 1ns / 1ps
`include "shape_pair_overlap_test_top_macros.svh"

module spot_checker import spot_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       first_is_circle_i,
  input logic       second_is_circle_i,
  input logic       valid_o,
  input logic [1:0] pair_kind_o
);

  logic [3:0] live_q;
  logic [3:0] acc_q;
  logic [3:0] first_circ_q;
  logic [3:0] second_circ_q;
  logic       settled;
  logic       exp_kind_box_circle;
  logic       exp_kind_circle;
  logic       kind_match;
  logic       kind_known;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= '0;
      acc_q  <= '0;
    end else begin
      live_q <= {live_q[2:0], 1'b1};
      acc_q  <= {acc_q[2:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    first_circ_q  <= {first_circ_q[2:0], first_is_circle_i};
    second_circ_q <= {second_circ_q[2:0], second_is_circle_i};
  end

  assign settled             = live_q[3];
  assign exp_kind_box_circle = first_circ_q[3] ^ second_circ_q[3];
  assign exp_kind_circle     = first_circ_q[3] & second_circ_q[3];
  assign kind_match = exp_kind_box_circle ? (pair_kind_o == PAIR_BOX_CIRCLE) :
                      exp_kind_circle     ? (pair_kind_o == PAIR_CIRCLE_CIRCLE) :
                                            (pair_kind_o == PAIR_BOX_BOX);
  assign kind_known = (pair_kind_o == PAIR_BOX_BOX) ||
                      (pair_kind_o == PAIR_CIRCLE_CIRCLE) ||
                      (pair_kind_o == PAIR_BOX_CIRCLE);

  `SPOT_ASSERT_NOW(a_latency, clk_i, rst_ni, settled, valid_o == acc_q[3], "strobe off latency")
  `SPOT_ASSERT_NOW(a_kind, clk_i, rst_ni, settled && valid_o, kind_match, "pair kind wrong")
  `SPOT_ASSERT_NOW(a_kind_code, clk_i, rst_ni, valid_o, kind_known, "unused pair kind code")
  `SPOT_ASSERT_NEXT(a_no_busy, clk_i, rst_ni, start_i, !busy_o, "pipeline raised busy")

endmodule

bind shape_pair_overlap_test_top spot_checker u_spot_checker (.*);
